// File: sv/sector_cache_lru_unit_defines.svh
// Assertion helpers used by the sector cache back end.
`ifndef SECTOR_CACHE_LRU_UNIT_DEFINES_SVH
`define SECTOR_CACHE_LRU_UNIT_DEFINES_SVH

// Plain invariant, checked at every clock edge outside reset.
`define SCL_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked in the same cycle.
`define SCL_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

// File: sv/scl_pkg.sv
// ----------------------------------------------------------------------------
// Sector cache package
// Shared constants, codes and the transaction type passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package scl_pkg;

  localparam int LINES_DEF       = 64;
  localparam int TRACKS_DEF      = 64;
  localparam int SECTORS_DEF     = 64;
  localparam int SECTOR_WORDS_DEF = 32;

  localparam int KEY_MAX_W   = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int LC_W        = 7;
  localparam int CFG_W       = 7;

  localparam logic CFG_ENABLE     = 1'b0;
  localparam logic CFG_LINE_COUNT = 1'b1;

  typedef enum logic [2:0] {
    ST_HIT         = 3'd0,
    ST_MISS        = 3'd1,
    ST_INSERTED    = 3'd2,
    ST_UPDATED     = 3'd3,
    ST_NOT_ENABLED = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    OP_NOTEN = 2'd0,
    OP_GET   = 2'd1,
    OP_PUT0  = 2'd2,
    OP_PUTW  = 2'd3
  } op_e;

  typedef struct packed {
    op_e                  op;
    logic                 key_ok;
    logic [KEY_MAX_W-1:0] key;
    logic [4:0]           widx;
    logic [63:0]          data;
  } item_t;

endpackage

`default_nettype wire

// File: sv/scl_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module scl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// File: sv/scl_front.sv
// ----------------------------------------------------------------------------
// Sector cache front end
// Accepts input transactions, forms the key and classifies each one.
// ----------------------------------------------------------------------------
`default_nettype none

module scl_front
  import scl_pkg::*;
#(
  parameter int TRACKS            = TRACKS_DEF,
  parameter int SECTORS_PER_TRACK = SECTORS_DEF,
  parameter int SECTOR_WORDS      = SECTOR_WORDS_DEF
) (
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        command_i,
  input  wire logic [5:0]  track_i,
  input  wire logic [5:0]  sector_i,
  input  wire logic [4:0]  word_index_i,
  input  wire logic [63:0] write_word_i,
  input  wire logic        enable_i,
  input  wire logic        q_full_i,
  input  wire logic        clearing_i,
  output logic             push_o,
  output item_t            item_o
);

  logic key_ok;
  logic drop;

  assign key_ok = (KEY_MAX_W'(track_i) < KEY_MAX_W'(TRACKS)) &&
                  (KEY_MAX_W'(sector_i) < KEY_MAX_W'(SECTORS_PER_TRACK));

  always_comb begin
    item_o.key_ok = key_ok;
    item_o.key    = key_ok ? KEY_MAX_W'(KEY_MAX_W'(track_i) * KEY_MAX_W'(SECTORS_PER_TRACK)
                    + KEY_MAX_W'(sector_i)) : '0;
    item_o.widx   = word_index_i;
    item_o.data   = write_word_i;
    drop          = 1'b0;
    if (!enable_i) begin
      item_o.op = OP_NOTEN;
    end else if (!command_i) begin
      item_o.op = OP_GET;
    end else if (word_index_i == 5'd0) begin
      item_o.op = OP_PUT0;
      drop      = !key_ok;
    end else begin
      item_o.op = OP_PUTW;
      drop      = (7'(word_index_i) >= 7'(SECTOR_WORDS));
    end
  end

  assign in_stall_o = q_full_i || clearing_i;
  assign push_o     = in_valid_i && !in_stall_o && !drop;

endmodule

`default_nettype wire

// File: sv/scl_queue.sv
// ----------------------------------------------------------------------------
// Sector cache decoupling queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module scl_queue
  import scl_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  item_t      item_i,
  output logic       full_o,
  output logic       valid_o,
  input  wire logic  pop_i,
  output item_t      item_o
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  item_t         slot_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [NW-1:0] num_q, num_d;
  logic          do_pop;

  assign full_o  = (num_q == NW'(QUEUE_DEPTH));
  assign valid_o = (num_q != '0);
  assign item_o  = slot_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    num_d = num_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(wr_q + 1'b1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(rd_q + 1'b1);
    end
    if (push_i && !do_pop) begin
      num_d = NW'(num_q + 1'b1);
    end else if (!push_i && do_pop) begin
      num_d = NW'(num_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      num_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      num_q <= num_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// File: sv/scl_back.sv
// ----------------------------------------------------------------------------
// Sector cache back end
// Sequencer that owns the presence table, line memories, ages and results.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sector_cache_lru_unit_defines.svh"

module scl_back
  import scl_pkg::*;
#(
  parameter int LINES             = LINES_DEF,
  parameter int TRACKS            = TRACKS_DEF,
  parameter int SECTORS_PER_TRACK = SECTORS_DEF,
  parameter int SECTOR_WORDS      = SECTOR_WORDS_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_valid_i,
  input  item_t                q_item_i,
  output logic                 pop_o,
  input  wire logic [LC_W-1:0] line_count_i,
  output logic                 clearing_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic [2:0]           status_o,
  output logic [4:0]           word_position_o,
  output logic [63:0]          read_word_o,
  output logic                 last_o,
  output logic [31:0]          get_count_o,
  output logic [31:0]          hit_count_o,
  output logic [31:0]          miss_count_o,
  output logic [31:0]          insert_count_o
);

  localparam int KEYS = TRACKS * SECTORS_PER_TRACK;
  localparam int KW   = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam int LW   = $clog2(LINES);
  localparam int CW   = $clog2(LINES + 1);
  localparam int WW   = (SECTOR_WORDS > 1) ? $clog2(SECTOR_WORDS) : 1;
  localparam int SD   = LINES * SECTOR_WORDS;
  localparam int SAW  = $clog2(SD);
  localparam int PW   = LW + 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_PRES, S_SCAN, S_VTAG, S_EVICT, S_INSTALL,
    S_TOUCH_A, S_TOUCH_B, S_TOUCH_S, S_TOUCH_Z, S_STR_RD, S_STR_WAIT, S_EMIT
  } state_e;

  state_e         state_q, state_d;
  item_t          item_q, item_d;
  logic [KW-1:0]  clr_q, clr_d;
  logic [CW-1:0]  taken_q, taken_d;
  logic [LW-1:0]  target_q, target_d;
  logic [LW-1:0]  cur_q, cur_d;
  logic           run_q, run_d;
  logic           ins_q, ins_d;
  logic [CW-1:0]  idx_q, idx_d;
  logic [LW-1:0]  best_q, best_d;
  logic [LW-1:0]  best_age_q, best_age_d;
  logic [LW-1:0]  ref_age_q, ref_age_d;
  logic [WW-1:0]  w_q, w_d;
  status_e        res_q, res_d;
  logic [31:0]    gets_q, gets_d, hits_q, hits_d, miss_q, miss_d, ins_cnt_q, ins_cnt_d;
  logic           out_valid_q, out_valid_d;
  status_e        out_status_q, out_status_d;
  logic [4:0]     out_pos_q, out_pos_d;
  logic [63:0]    out_word_q, out_word_d;
  logic           out_last_q, out_last_d;
  logic [31:0]    out_gets_q, out_gets_d, out_hits_q, out_hits_d;
  logic [31:0]    out_miss_q, out_miss_d, out_ins_q, out_ins_d;

  logic           pres_we;
  logic [KW-1:0]  pres_waddr;
  logic [PW-1:0]  pres_wdata, pres_rdata;
  logic           tags_we;
  logic [LW-1:0]  tags_waddr;
  logic [KW-1:0]  tags_rdata;
  logic           ages_we;
  logic [LW-1:0]  ages_waddr, ages_raddr, ages_wdata, ages_rdata;
  logic           store_we;
  logic [SAW-1:0] store_waddr, store_raddr;
  logic [63:0]    store_wdata;
  logic [63:0]    store_rdata;

  logic [KW-1:0]  key;
  logic [8:0]     lc9;
  logic [CW-1:0]  eff;
  logic           slot_free;
  logic           load;

  assign key = item_q.key[KW-1:0];
  assign lc9 = 9'(line_count_i);
  assign eff = (lc9 == 9'd0) ? CW'(1) : ((lc9 > 9'(LINES)) ? CW'(LINES) : CW'(lc9));
  assign slot_free = !out_valid_q || !out_stall_i;
  assign store_raddr = SAW'(SAW'(cur_q) * SAW'(SECTOR_WORDS) + SAW'(w_q));

  scl_ram #(.WIDTH(PW), .DEPTH(KEYS)) u_pres (
    .clk_i, .we_i(pres_we), .waddr_i(pres_waddr), .wdata_i(pres_wdata),
    .raddr_i(q_item_i.key[KW-1:0]), .rdata_o(pres_rdata)
  );

  scl_ram #(.WIDTH(KW), .DEPTH(LINES)) u_tags (
    .clk_i, .we_i(tags_we), .waddr_i(tags_waddr), .wdata_i(key),
    .raddr_i(best_q), .rdata_o(tags_rdata)
  );

  scl_ram #(.WIDTH(LW), .DEPTH(LINES)) u_ages (
    .clk_i, .we_i(ages_we), .waddr_i(ages_waddr), .wdata_i(ages_wdata),
    .raddr_i(ages_raddr), .rdata_o(ages_rdata)
  );

  scl_ram #(.WIDTH(64), .DEPTH(SD)) u_store (
    .clk_i, .we_i(store_we), .waddr_i(store_waddr), .wdata_i(store_wdata),
    .raddr_i(store_raddr), .rdata_o(store_rdata)
  );

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    clr_d        = clr_q;
    taken_d      = taken_q;
    target_d     = target_q;
    cur_d        = cur_q;
    run_d        = run_q;
    ins_d        = ins_q;
    idx_d        = idx_q;
    best_d       = best_q;
    best_age_d   = best_age_q;
    ref_age_d    = ref_age_q;
    w_d          = w_q;
    res_d        = res_q;
    gets_d       = gets_q;
    hits_d       = hits_q;
    miss_d       = miss_q;
    ins_cnt_d    = ins_cnt_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_pos_d    = out_pos_q;
    out_word_d   = out_word_q;
    out_last_d   = out_last_q;
    out_gets_d   = out_gets_q;
    out_hits_d   = out_hits_q;
    out_miss_d   = out_miss_q;
    out_ins_d    = out_ins_q;
    load         = 1'b0;
    pop_o        = 1'b0;
    pres_we      = 1'b0;
    pres_waddr   = key;
    pres_wdata   = '0;
    tags_we      = 1'b0;
    tags_waddr   = best_q;
    ages_we      = 1'b0;
    ages_waddr   = cur_q;
    ages_wdata   = '0;
    ages_raddr   = idx_q[LW-1:0];
    store_we     = 1'b0;
    store_waddr  = SAW'(SAW'(target_q) * SAW'(SECTOR_WORDS) + SAW'(item_q.widx));
    store_wdata  = item_q.data;

    case (state_q)
      S_CLEAR: begin
        pres_we    = 1'b1;
        pres_waddr = clr_q;
        if (clr_q == KW'(KEYS - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = KW'(clr_q + 1'b1);
        end
      end
      S_IDLE: begin
        if (q_valid_i) begin
          pop_o  = 1'b1;
          item_d = q_item_i;
          case (q_item_i.op)
            OP_NOTEN: begin
              res_d   = ST_NOT_ENABLED;
              state_d = S_EMIT;
            end
            OP_GET: begin
              gets_d = gets_q + 32'd1;
              if (q_item_i.key_ok) begin
                state_d = S_PRES;
              end else begin
                miss_d  = miss_q + 32'd1;
                res_d   = ST_MISS;
                state_d = S_EMIT;
              end
            end
            OP_PUT0: begin
              state_d = S_PRES;
            end
            default: begin
              if (run_q) begin
                store_we    = 1'b1;
                store_waddr = SAW'(SAW'(target_q) * SAW'(SECTOR_WORDS)
                              + SAW'(q_item_i.widx));
                store_wdata = q_item_i.data;
                item_d.data = q_item_i.data;
                if (7'(q_item_i.widx) == 7'(SECTOR_WORDS - 1)) begin
                  run_d   = 1'b0;
                  res_d   = ins_q ? ST_INSERTED : ST_UPDATED;
                  state_d = S_EMIT;
                end
              end
            end
          endcase
        end
      end
      S_PRES: begin
        if (item_q.op == OP_GET) begin
          if (pres_rdata[LW]) begin
            hits_d  = hits_q + 32'd1;
            cur_d   = pres_rdata[LW-1:0];
            state_d = S_TOUCH_A;
          end else begin
            miss_d  = miss_q + 32'd1;
            res_d   = ST_MISS;
            state_d = S_EMIT;
          end
        end else if (pres_rdata[LW]) begin
          ins_d   = 1'b0;
          cur_d   = pres_rdata[LW-1:0];
          state_d = S_TOUCH_A;
        end else begin
          ins_d     = 1'b1;
          ins_cnt_d = ins_cnt_q + 32'd1;
          if (taken_q < eff) begin
            ages_we    = 1'b1;
            ages_waddr = LW'(taken_q);
            ages_wdata = LW'(taken_q);
            tags_we    = 1'b1;
            tags_waddr = LW'(taken_q);
            pres_we    = 1'b1;
            pres_wdata = {1'b1, LW'(taken_q)};
            cur_d      = LW'(taken_q);
            taken_d    = CW'(taken_q + 1'b1);
            state_d    = S_TOUCH_A;
          end else begin
            idx_d   = '0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (idx_q != '0) begin
          if (idx_q == CW'(1) || ages_rdata > best_age_q) begin
            best_d     = LW'(idx_q - 1'b1);
            best_age_d = ages_rdata;
          end
        end
        if (idx_q == eff) begin
          state_d = S_VTAG;
        end else begin
          idx_d = CW'(idx_q + 1'b1);
        end
      end
      S_VTAG: begin
        state_d = S_EVICT;
      end
      S_EVICT: begin
        if (KW'(tags_rdata) < KW'(KEYS - 1) || tags_rdata == KW'(KEYS - 1)) begin
          pres_we    = 1'b1;
          pres_waddr = tags_rdata;
        end
        tags_we = 1'b1;
        state_d = S_INSTALL;
      end
      S_INSTALL: begin
        pres_we    = 1'b1;
        pres_wdata = {1'b1, best_q};
        cur_d      = best_q;
        state_d    = S_TOUCH_A;
      end
      S_TOUCH_A: begin
        ages_raddr = cur_q;
        state_d    = S_TOUCH_B;
      end
      S_TOUCH_B: begin
        ref_age_d = ages_rdata;
        idx_d     = '0;
        state_d   = S_TOUCH_S;
      end
      S_TOUCH_S: begin
        if (idx_q != '0 && ages_rdata < ref_age_q) begin
          ages_we    = 1'b1;
          ages_waddr = LW'(idx_q - 1'b1);
          ages_wdata = LW'(ages_rdata + 1'b1);
        end
        if (idx_q == taken_q) begin
          state_d = S_TOUCH_Z;
        end else begin
          idx_d = CW'(idx_q + 1'b1);
        end
      end
      S_TOUCH_Z: begin
        ages_we    = 1'b1;
        ages_waddr = cur_q;
        ages_wdata = '0;
        if (item_q.op == OP_GET) begin
          w_d     = '0;
          state_d = S_STR_RD;
        end else begin
          store_we    = 1'b1;
          store_waddr = SAW'(SAW'(cur_q) * SAW'(SECTOR_WORDS));
          target_d    = cur_q;
          run_d       = 1'b1;
          state_d     = S_IDLE;
          if (SECTOR_WORDS == 1) begin
            run_d   = 1'b0;
            res_d   = ins_q ? ST_INSERTED : ST_UPDATED;
            state_d = S_EMIT;
          end
        end
      end
      S_STR_RD: begin
        state_d = S_STR_WAIT;
      end
      S_STR_WAIT: begin
        if (slot_free) begin
          load         = 1'b1;
          out_status_d = ST_HIT;
          out_pos_d    = 5'(w_q);
          out_word_d   = store_rdata;
          out_last_d   = (w_q == WW'(SECTOR_WORDS - 1));
          if (w_q == WW'(SECTOR_WORDS - 1)) begin
            state_d = S_IDLE;
          end else begin
            w_d     = WW'(w_q + 1'b1);
            state_d = S_STR_RD;
          end
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          load         = 1'b1;
          out_status_d = res_q;
          out_pos_d    = '0;
          out_word_d   = '0;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (load) begin
      out_valid_d = 1'b1;
      out_gets_d  = gets_q;
      out_hits_d  = hits_q;
      out_miss_d  = miss_q;
      out_ins_d   = ins_cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      item_q       <= '0;
      clr_q        <= '0;
      taken_q      <= '0;
      target_q     <= '0;
      cur_q        <= '0;
      run_q        <= 1'b0;
      ins_q        <= 1'b0;
      idx_q        <= '0;
      best_q       <= '0;
      best_age_q   <= '0;
      ref_age_q    <= '0;
      w_q          <= '0;
      res_q        <= ST_MISS;
      gets_q       <= '0;
      hits_q       <= '0;
      miss_q       <= '0;
      ins_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_MISS;
      out_pos_q    <= '0;
      out_word_q   <= '0;
      out_last_q   <= 1'b0;
      out_gets_q   <= '0;
      out_hits_q   <= '0;
      out_miss_q   <= '0;
      out_ins_q    <= '0;
    end else begin
      state_q      <= state_d;
      item_q       <= item_d;
      clr_q        <= clr_d;
      taken_q      <= taken_d;
      target_q     <= target_d;
      cur_q        <= cur_d;
      run_q        <= run_d;
      ins_q        <= ins_d;
      idx_q        <= idx_d;
      best_q       <= best_d;
      best_age_q   <= best_age_d;
      ref_age_q    <= ref_age_d;
      w_q          <= w_d;
      res_q        <= res_d;
      gets_q       <= gets_d;
      hits_q       <= hits_d;
      miss_q       <= miss_d;
      ins_cnt_q    <= ins_cnt_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_pos_q    <= out_pos_d;
      out_word_q   <= out_word_d;
      out_last_q   <= out_last_d;
      out_gets_q   <= out_gets_d;
      out_hits_q   <= out_hits_d;
      out_miss_q   <= out_miss_d;
      out_ins_q    <= out_ins_d;
    end
  end

  assign clearing_o      = (state_q == S_CLEAR);
  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign word_position_o = out_pos_q;
  assign read_word_o     = out_word_q;
  assign last_o          = out_last_q;
  assign get_count_o     = out_gets_q;
  assign hit_count_o     = out_hits_q;
  assign miss_count_o    = out_miss_q;
  assign insert_count_o  = out_ins_q;

  `SCL_ASSERT(a_taken_bound, taken_q <= CW'(LINES), "more lines taken than exist")
  `SCL_ASSERT_IMPL(a_clear_quiet, state_q == S_CLEAR, !out_valid_q, "result during clear")
  `SCL_ASSERT_IMPL(a_single_last, out_valid_q && out_status_q != ST_HIT, out_last_q,
                   "single result without last")
  `SCL_ASSERT_IMPL(a_hits_bound, state_q == S_IDLE, hits_q + miss_q == gets_q,
                   "get counters disagree")

endmodule

`default_nettype wire

// File: sv/sector_cache_lru_unit.sv
// ----------------------------------------------------------------------------
// Sector cache with least-recently-used replacement
// Fully associative cache of sectors keyed by track and sector number.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Payload
//  in        in_valid_i/in_stall_o  command, track, sector, word_index, write_word
//  out       out_valid_o/out_stall_i status, word_position, read_word, last, counts
//  cfg       cfg_we_i               cfg_index_i, cfg_wdata_i
//
// A put word after word zero is stored as it is popped; a miss reports at once for
// a key out of range, else after the presence lookup. A hit or word zero looks up
// the presence table, then updates the ages over the taken lines, with one more
// pass over the lines in use first when a line is evicted; a hit then streams its
// words through the single read port of the line store. After reset all presence
// entries (TRACKS * SECTORS_PER_TRACK) are cleared while in_stall_o stays high.
// A stalled result holds the back end; the two-entry queue takes input until full.
`default_nettype none

module sector_cache_lru_unit
  import scl_pkg::*;
#(
  parameter int LINES             = LINES_DEF,
  parameter int TRACKS            = TRACKS_DEF,
  parameter int SECTORS_PER_TRACK = SECTORS_DEF,
  parameter int SECTOR_WORDS      = SECTOR_WORDS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_index_i,
  input  wire logic [CFG_W-1:0] cfg_wdata_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic             command_i,
  input  wire logic [5:0]       track_i,
  input  wire logic [5:0]       sector_i,
  input  wire logic [4:0]       word_index_i,
  input  wire logic [63:0]      write_word_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [2:0]            status_o,
  output logic [4:0]            word_position_o,
  output logic [63:0]           read_word_o,
  output logic                  last_o,
  output logic [31:0]           get_count_o,
  output logic [31:0]           hit_count_o,
  output logic [31:0]           miss_count_o,
  output logic [31:0]           insert_count_o
);

  logic            enable_q;
  logic [LC_W-1:0] line_count_q;
  logic            push, q_full, q_valid, pop, clearing;
  item_t           push_item, head_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= 1'b0;
      line_count_q <= LC_W'(64);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ENABLE:     enable_q     <= cfg_wdata_i[0];
        CFG_LINE_COUNT: line_count_q <= cfg_wdata_i[LC_W-1:0];
        default:        enable_q     <= enable_q;
      endcase
    end
  end

  scl_front #(
    .TRACKS(TRACKS), .SECTORS_PER_TRACK(SECTORS_PER_TRACK), .SECTOR_WORDS(SECTOR_WORDS)
  ) u_front (
    .in_valid_i, .in_stall_o, .command_i, .track_i, .sector_i, .word_index_i,
    .write_word_i, .enable_i(enable_q), .q_full_i(q_full), .clearing_i(clearing),
    .push_o(push), .item_o(push_item)
  );

  scl_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .item_i(push_item), .full_o(q_full),
    .valid_o(q_valid), .pop_i(pop), .item_o(head_item)
  );

  scl_back #(
    .LINES(LINES), .TRACKS(TRACKS), .SECTORS_PER_TRACK(SECTORS_PER_TRACK),
    .SECTOR_WORDS(SECTOR_WORDS)
  ) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_item_i(head_item), .pop_o(pop),
    .line_count_i(line_count_q), .clearing_o(clearing), .out_valid_o, .out_stall_i,
    .status_o, .word_position_o, .read_word_o, .last_o, .get_count_o, .hit_count_o,
    .miss_count_o, .insert_count_o
  );

endmodule

`default_nettype wire
